// ===== rtl/d8_flow_direction_assert.svh =====
// Assertion macros shared by the flow direction RTL.
`ifndef D8_FLOW_DIRECTION_ASSERT_SVH
`define D8_FLOW_DIRECTION_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define D8FD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define D8FD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/d8fd_pkg.sv =====
// Shared types and constants for the D8 flow direction block.
package d8fd_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int ELEV_BITS_DEFAULT = 32;

  // Fixed field widths of the result word and the configuration port.
  localparam int CELL_ROW_BITS = 16;
  localparam int CELL_COL_BITS = 12;
  localparam int DIR_BITS      = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam int WIDTH_BITS    = 13;

  // Register values after reset.
  localparam int RASTER_WIDTH_RESET  = 4096;
  localparam int RASTER_HEIGHT_RESET = 3;

  // Depth of the queues between the parts.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_RASTER_WIDTH  = 1'b0,
    REG_RASTER_HEIGHT = 1'b1
  } reg_index_t;

  // Neighbour positions in priority order; the centre follows them.
  typedef enum logic [2:0] {
    DIR_E  = 3'd0,
    DIR_SE = 3'd1,
    DIR_S  = 3'd2,
    DIR_SW = 3'd3,
    DIR_W  = 3'd4,
    DIR_NW = 3'd5,
    DIR_N  = 3'd6,
    DIR_NE = 3'd7
  } dir_t;

  localparam int NB_COUNT   = 9;
  localparam int NB_CENTRE  = 8;

  // Per-cell control that travels with the window.
  typedef struct packed {
    logic                     interior;
    logic                     last;
    logic [CELL_ROW_BITS-1:0] row;
    logic [CELL_COL_BITS-1:0] col;
  } info_t;

  // One result word.
  typedef struct packed {
    logic [DIR_BITS-1:0]      direction;
    logic [CELL_ROW_BITS-1:0] row;
    logic [CELL_COL_BITS-1:0] col;
    logic                     last;
  } out_t;

endpackage

// ===== rtl/d8fd_fifo.sv =====
// Small register-based first-in first-out queue.
`include "d8_flow_direction_assert.svh"

module d8fd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = d8fd_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `D8FD_ASSERT_NOW(fifo_count_bound, 1'b1, count <= CNT_W'(DEPTH), "fifo count above depth")
  `D8FD_ASSERT_NEXT(fifo_count_up, do_push && !do_pop, count == $past(count) + 1'b1, "fifo count did not grow on push")

endmodule

// ===== rtl/d8fd_front.sv =====
// Front part: position counters, line stores and the 3x3 window.
`include "d8_flow_direction_assert.svh"

module d8fd_front #(
  parameter int MAX_WIDTH = d8fd_pkg::MAX_WIDTH_DEFAULT,
  parameter int ELEV_BITS = d8fd_pkg::ELEV_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Sample input.
  input  logic                                push,
  input  logic signed [ELEV_BITS-1:0]         elevation,
  output logic                                full,
  // Configuration writes.
  input  logic                                cfg_write,
  input  logic [0:0]                          cfg_index,
  input  logic [d8fd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // Window words toward the back part.
  output logic                                q_push,
  output logic [$bits(d8fd_pkg::info_t)+d8fd_pkg::NB_COUNT*ELEV_BITS-1:0] q_din,
  input  logic                                q_full
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = d8fd_pkg::CELL_ROW_BITS;
  localparam int RESET_LAST_COL =
    ((d8fd_pkg::RASTER_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : d8fd_pkg::RASTER_WIDTH_RESET) - 1;
  localparam int RESET_LAST_ROW = d8fd_pkg::RASTER_HEIGHT_RESET - 1;
  localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);

  // Configuration, kept as the last valid column and row.
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic [16:0]      width_req;
  logic [16:0]      width_eff;
  logic [ROW_W-1:0] height_eff;

  // Position of the next sample.
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             wrap_col;
  logic             wrap_row;
  logic             accept;

  // Stage holding the accepted sample while the line stores are read.
  logic                  a_valid;
  logic                  a_emit;
  logic [COL_W-1:0]      a_slot;
  logic [ELEV_BITS-1:0]  a_sample;
  d8fd_pkg::info_t       a_info;
  logic                  a_adv;
  logic [ELEV_BITS-1:0]  rd_top;
  logic [ELEV_BITS-1:0]  rd_mid;

  // Line stores: row two back and row one back.
  logic [ELEV_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [ELEV_BITS-1:0] lower_mem [MAX_WIDTH];

  // Window columns: 0..2 are two columns back, 3..5 one column back (top, mid, bottom).
  logic [5:0][ELEV_BITS-1:0] wc;
  logic [d8fd_pkg::NB_COUNT-1:0][ELEV_BITS-1:0] nb;

  // Clamp the requested sizes to their legal ranges.
  always_comb begin
    width_req  = 17'(cfg_data[d8fd_pkg::WIDTH_BITS-1:0]);
    width_eff  = (width_req < 17'd3) ? 17'd3 : ((width_req > MAX_W17) ? MAX_W17 : width_req);
    height_eff = (cfg_data < 16'd3) ? 16'd3 : cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= COL_W'(RESET_LAST_COL);
      last_row <= ROW_W'(RESET_LAST_ROW);
    end else if (cfg_write) begin
      unique case (cfg_index)
        d8fd_pkg::REG_RASTER_WIDTH:  last_col <= COL_W'(width_eff - 17'd1);
        d8fd_pkg::REG_RASTER_HEIGHT: last_row <= height_eff - 16'd1;
        default: ;
      endcase
    end
  end

  // Handshake: the stage frees when its word moves on or carries no result.
  assign a_adv    = a_valid && (!a_emit || !q_full);
  assign full     = a_valid && !a_adv;
  assign accept   = push && !full;
  assign q_push   = a_valid && a_emit && !q_full;
  assign wrap_col = (col >= last_col);
  assign wrap_row = (row >= last_row);

  // Position counters advance on every accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (wrap_col) begin
        col <= '0;
        row <= wrap_row ? '0 : row + 16'd1;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  // Stage payload: the cell described is one row up and one column left.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample        <= elevation;
      a_slot          <= col;
      a_emit          <= (col != '0) && (row != '0);
      a_info.interior <= (col >= COL_W'(2)) && (row >= 16'd2) &&
                         (col <= last_col) && (row <= last_row);
      a_info.last     <= wrap_col && wrap_row;
      a_info.row      <= row - 16'd1;
      a_info.col      <= d8fd_pkg::CELL_COL_BITS'(col - COL_W'(1));
    end
  end

  // Line store read on accept, write back when the stage moves on.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_top <= upper_mem[col];
      rd_mid <= lower_mem[col];
    end
    if (a_adv) begin
      upper_mem[a_slot] <= rd_mid;
      lower_mem[a_slot] <= a_sample;
    end
  end

  // Window shifts by one column with every sample.
  always_ff @(posedge clk) begin
    if (a_adv) begin
      wc[0] <= wc[3];
      wc[1] <= wc[4];
      wc[2] <= wc[5];
      wc[3] <= rd_top;
      wc[4] <= rd_mid;
      wc[5] <= a_sample;
    end
  end

  // Gather the eight neighbours and the centre.
  always_comb begin
    nb[d8fd_pkg::DIR_E]     = rd_mid;
    nb[d8fd_pkg::DIR_SE]    = a_sample;
    nb[d8fd_pkg::DIR_S]     = wc[5];
    nb[d8fd_pkg::DIR_SW]    = wc[2];
    nb[d8fd_pkg::DIR_W]     = wc[1];
    nb[d8fd_pkg::DIR_NW]    = wc[0];
    nb[d8fd_pkg::DIR_N]     = wc[3];
    nb[d8fd_pkg::DIR_NE]    = rd_top;
    nb[d8fd_pkg::NB_CENTRE] = wc[4];
  end

  assign q_din = {a_info, nb};

  `D8FD_ASSERT_NEXT(front_col_wrap, accept && wrap_col, col == '0, "column counter did not wrap")

endmodule

// ===== rtl/d8fd_back.sv =====
// Back part: pipelined minimum search over the neighbours and code generation.
`include "d8_flow_direction_assert.svh"

module d8fd_back #(
  parameter int ELEV_BITS = d8fd_pkg::ELEV_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  logic [$bits(d8fd_pkg::info_t)+d8fd_pkg::NB_COUNT*ELEV_BITS-1:0] q_dout,
  output logic                   q_pop,
  input  logic                   o_full,
  output logic                   o_push,
  output d8fd_pkg::out_t         o_din
);

  localparam int E = ELEV_BITS;

  d8fd_pkg::info_t                       in_info;
  logic [d8fd_pkg::NB_COUNT-1:0][E-1:0]  in_nb;
  logic                                  advance;

  // Stage 1: four pair winners.
  logic                   v1;
  logic [3:0][E-1:0]      val1;
  logic [3:0][2:0]        idx1;
  logic [E-1:0]           ctr1;
  d8fd_pkg::info_t        info1;
  logic [3:0][E-1:0]      val1_next;
  logic [3:0][2:0]        idx1_next;

  // Stage 2: two winners.
  logic                   v2;
  logic [1:0][E-1:0]      val2;
  logic [1:0][2:0]        idx2;
  logic [E-1:0]           ctr2;
  d8fd_pkg::info_t        info2;
  logic [1:0][E-1:0]      val2_next;
  logic [1:0][2:0]        idx2_next;

  // Stage 3: overall lowest neighbour.
  logic                   v3;
  logic [E-1:0]           val3;
  logic [2:0]             idx3;
  logic [E-1:0]           ctr3;
  d8fd_pkg::info_t        info3;

  // Stage 4: finished result word.
  logic                   v4;
  d8fd_pkg::out_t         res4;
  d8fd_pkg::out_t         res4_next;

  assign in_info = q_dout[$bits(q_dout)-1 -: $bits(d8fd_pkg::info_t)];
  assign in_nb   = q_dout[d8fd_pkg::NB_COUNT*E-1:0];

  // The whole pipeline holds while the last word cannot leave.
  assign advance = !(v4 && o_full);
  assign q_pop   = !q_empty && advance;
  assign o_push  = v4 && !o_full;
  assign o_din   = res4;

  // Pair compares; the later position wins only when strictly lower.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if ($signed(in_nb[2*k+1]) < $signed(in_nb[2*k])) begin
        val1_next[k] = in_nb[2*k+1];
        idx1_next[k] = 3'(2*k+1);
      end else begin
        val1_next[k] = in_nb[2*k];
        idx1_next[k] = 3'(2*k);
      end
    end
    for (int k = 0; k < 2; k++) begin
      if ($signed(val1[2*k+1]) < $signed(val1[2*k])) begin
        val2_next[k] = val1[2*k+1];
        idx2_next[k] = idx1[2*k+1];
      end else begin
        val2_next[k] = val1[2*k];
        idx2_next[k] = idx1[2*k];
      end
    end
  end

  // A code is given only for an interior cell with a neighbour below the centre.
  always_comb begin
    res4_next.row       = info3.row;
    res4_next.col       = info3.col;
    res4_next.last      = info3.last;
    res4_next.direction = '0;
    if (info3.interior && ($signed(val3) < $signed(ctr3))) begin
      res4_next.direction = d8fd_pkg::DIR_BITS'(1) << idx3;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= q_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (advance) begin
      val1  <= val1_next;
      idx1  <= idx1_next;
      ctr1  <= in_nb[d8fd_pkg::NB_CENTRE];
      info1 <= in_info;
      val2  <= val2_next;
      idx2  <= idx2_next;
      ctr2  <= ctr1;
      info2 <= info1;
      if ($signed(val2[1]) < $signed(val2[0])) begin
        val3 <= val2[1];
        idx3 <= idx2[1];
      end else begin
        val3 <= val2[0];
        idx3 <= idx2[0];
      end
      ctr3  <= ctr2;
      info3 <= info2;
      res4  <= res4_next;
    end
  end

  `D8FD_ASSERT_NOW(back_dir_onehot, v4, $onehot0(res4.direction), "direction code has several bits set")
  `D8FD_ASSERT_NEXT(back_stall_hold, v4 && o_full, v4 && $stable(res4), "result word changed while stalled")

endmodule

// ===== rtl/d8_flow_direction.sv =====
// Top level of the D8 flow direction block.
//
// Elevation words enter through a queue-style port (push/full) in row-major
// raster order, one word per cycle when nothing stalls. Result words leave
// through a queue-style port (empty/pop): each carries the flow code of one
// cell, its row and column, and a flag on the last cell of the raster.
// The result for cell (c,r) follows the word for (c+1,r+1); words in row 0
// or column 0 give none. After its word is accepted, a result passes the
// line store read stage, the window queue, the compare pipeline and the
// output queue. Throughput is one word per cycle when nothing stalls, set by
// the single read and write port of each line store.
// raster_width and raster_height are written through cfg_write/cfg_index/
// cfg_data while the block is idle. Reset sets 4096 by 3, zeroes the
// position counters and empties all queues; the line stores are not cleared
// and need no clearing pass. When the receiver stops popping, the output
// queue fills, the compare pipeline and window queue back up, and full rises.
module d8_flow_direction #(
  parameter int MAX_WIDTH = d8fd_pkg::MAX_WIDTH_DEFAULT,
  parameter int ELEV_BITS = d8fd_pkg::ELEV_BITS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  input  logic signed [ELEV_BITS-1:0]              elevation,
  output logic                                     full,
  output logic                                     empty,
  input  logic                                     pop,
  output logic [d8fd_pkg::DIR_BITS-1:0]            direction,
  output logic [d8fd_pkg::CELL_ROW_BITS-1:0]       cell_row,
  output logic [d8fd_pkg::CELL_COL_BITS-1:0]       cell_column,
  output logic                                     last_cell,
  input  logic                                     cfg_write,
  input  logic [0:0]                               cfg_index,
  input  logic [d8fd_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

  localparam int QW = $bits(d8fd_pkg::info_t) + d8fd_pkg::NB_COUNT * ELEV_BITS;
  localparam int OW = $bits(d8fd_pkg::out_t);

  logic           q_push;
  logic [QW-1:0]  q_din;
  logic           q_full;
  logic           q_pop;
  logic [QW-1:0]  q_dout;
  logic           q_empty;
  logic           o_push;
  d8fd_pkg::out_t o_din;
  logic           o_full;
  logic [OW-1:0]  o_dout;
  d8fd_pkg::out_t res;

  // Front part: counters, line stores and window.
  d8fd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ELEV_BITS (ELEV_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .elevation (elevation),
    .full      (full),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_din     (q_din),
    .q_full    (q_full)
  );

  // Window queue between the parts.
  d8fd_fifo #(
    .W     (QW),
    .DEPTH (d8fd_pkg::QUEUE_DEPTH)
  ) u_win_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Back part: compare pipeline.
  d8fd_back #(
    .ELEV_BITS (ELEV_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_din   (o_din)
  );

  // Output queue.
  d8fd_fifo #(
    .W     (OW),
    .DEPTH (d8fd_pkg::QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .din   (o_din),
    .full  (o_full),
    .pop   (pop),
    .dout  (o_dout),
    .empty (empty)
  );

  assign res         = o_dout;
  assign direction   = res.direction;
  assign cell_row    = res.row;
  assign cell_column = res.col;
  assign last_cell   = res.last;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the D8 flow direction block.
`timescale 1ns / 1ps

module tb_top;

  localparam int CELLS_MAX   = d8fd_pkg::MAX_WIDTH_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 12;

  typedef enum bit {PLAN_WRITE, PLAN_SAMPLE} plan_kind_t;

  // One row of the directed stimulus table.
  typedef struct {
    plan_kind_t           kind;
    d8fd_pkg::reg_index_t index;
    logic [31:0]          value;
    bit                   typed;
    d8fd_pkg::out_t       want_word;
  } plan_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               push = 1'b0;
  logic signed [31:0]                 elevation = '0;
  logic                               full;
  logic                               empty;
  logic                               pop = 1'b0;
  logic [d8fd_pkg::DIR_BITS-1:0]      direction;
  logic [d8fd_pkg::CELL_ROW_BITS-1:0] cell_row;
  logic [d8fd_pkg::CELL_COL_BITS-1:0] cell_column;
  logic                               last_cell;
  logic                               cfg_write = 1'b0;
  logic [0:0]                         cfg_index = '0;
  logic [d8fd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor state: two line stores, the window columns, the position and registers.
  logic [31:0]       older_row [CELLS_MAX];
  logic [31:0]       newer_row [CELLS_MAX];
  logic [31:0]       window_col [6];
  int unsigned       pos_col = 0;
  int unsigned       pos_row = 0;
  logic [12:0]       width_reg = 13'(d8fd_pkg::RASTER_WIDTH_RESET);
  logic [15:0]       height_reg = 16'(d8fd_pkg::RASTER_HEIGHT_RESET);

  d8fd_pkg::out_t pending_codes [$];
  plan_row_t      directed_plan [$];
  int             mismatches = 0;
  int             quiet_cycles = 0;
  int             send_gap_pct = 7;
  int             pop_stall_pct = 7;
  logic [31:0]    plateau = '0;
  d8fd_pkg::out_t seen_cell;
  d8fd_pkg::out_t want_cell;

  d8_flow_direction dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .elevation  (elevation),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .direction  (direction),
    .cell_row   (cell_row),
    .cell_column(cell_column),
    .last_cell  (last_cell),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver pops at random, with stall rate set by the current phase.
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input d8fd_pkg::out_t got,
                                 input d8fd_pkg::out_t want);
    mismatches++;
    $display("%0t ns: %s: got %0d/%0d/%0d/%0d, want %0d/%0d/%0d/%0d (dir/row/col/last)",
             $time, what, got.direction, got.row, got.col, got.last,
             want.direction, want.row, want.col, want.last);
  endtask

  // Work out the flow code for one accepted word and advance the predictor.
  task automatic predict_cell(input logic [31:0] sample, output bit made,
                              output d8fd_pkg::out_t code_word);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int          k;
    logic [31:0] above;
    logic [31:0] beside;
    logic [31:0] lowest;
    logic [31:0] nb [8];
    bit          wrap_col;
    bit          wrap_row;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > CELLS_MAX) w = CELLS_MAX;
    h = (height_reg < 3) ? 3 : height_reg;
    above = older_row[pos_col];
    beside = newer_row[pos_col];
    wrap_col = (pos_col >= w - 1);
    wrap_row = (pos_row >= h - 1);
    made = (pos_col >= 1) && (pos_row >= 1);
    code_word = '0;
    if (made) begin
      c = pos_col - 1;
      r = pos_row - 1;
      if (c >= 1 && r >= 1 && c <= w - 2 && r <= h - 2) begin
        nb[d8fd_pkg::DIR_E]  = beside;
        nb[d8fd_pkg::DIR_SE] = sample;
        nb[d8fd_pkg::DIR_S]  = window_col[5];
        nb[d8fd_pkg::DIR_SW] = window_col[2];
        nb[d8fd_pkg::DIR_W]  = window_col[1];
        nb[d8fd_pkg::DIR_NW] = window_col[0];
        nb[d8fd_pkg::DIR_N]  = window_col[3];
        nb[d8fd_pkg::DIR_NE] = above;
        // Strictly lower wins, so the earlier direction keeps a tie.
        lowest = window_col[4];
        for (k = 0; k < 8; k++) begin
          if ($signed(nb[k]) < $signed(lowest)) begin
            lowest = nb[k];
            code_word.direction = 8'(1 << k);
          end
        end
      end
      code_word.row = r[15:0];
      code_word.col = c[11:0];
      code_word.last = wrap_col && wrap_row;
    end
    older_row[pos_col] = beside;
    newer_row[pos_col] = sample;
    window_col[0] = window_col[3];
    window_col[1] = window_col[4];
    window_col[2] = window_col[5];
    window_col[3] = above;
    window_col[4] = beside;
    window_col[5] = sample;
    if (wrap_col) begin
      pos_col = 0;
      pos_row = wrap_row ? 0 : ((pos_row + 1) & 16'hFFFF);
    end else begin
      pos_col = pos_col + 1;
    end
  endtask

  // Offer one word, after optional idle cycles with noise on the data lines.
  task automatic push_sample(input logic [31:0] value, input bit typed,
                             input d8fd_pkg::out_t typed_cell);
    bit             made;
    d8fd_pkg::out_t code_word;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      elevation <= $urandom();
      @(negedge clk);
    end
    push <= 1'b1;
    elevation <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_cell(value, made, code_word);
    if (typed) pending_codes = {pending_codes, typed_cell};
    else if (made) pending_codes = {pending_codes, code_word};
    @(negedge clk);
  endtask

  // Hold off the sender until every expected code has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
  endtask

  // Write one register once the block has gone idle.
  task automatic set_register(input d8fd_pkg::reg_index_t index, input logic [15:0] value);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (index == d8fd_pkg::REG_RASTER_WIDTH) width_reg = value[12:0];
    else height_reg = value;
  endtask

  // Draw an elevation: full range, near-ties, extremes or values around zero.
  function automatic logic [31:0] random_elevation();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return plateau + $urandom_range(0, 2);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  task automatic stream_samples(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 32 == 0) plateau = $urandom();
      push_sample(random_elevation(), 1'b0, '0);
    end
  endtask

  // Send random words until the raster wraps back to its first cell.
  task automatic finish_raster();
    while (pos_col != 0 || pos_row != 0) push_sample(random_elevation(), 1'b0, '0);
  endtask

  task automatic plan_write(input d8fd_pkg::reg_index_t index, input logic [15:0] value);
    plan_row_t row;
    row = '{PLAN_WRITE, index, 32'(value), 1'b0, '0};
    directed_plan = {directed_plan, row};
  endtask

  task automatic plan_sample(input logic [31:0] value);
    plan_row_t row;
    row = '{PLAN_SAMPLE, d8fd_pkg::REG_RASTER_WIDTH, value, 1'b0, '0};
    directed_plan = {directed_plan, row};
  endtask

  task automatic plan_checked(input logic [31:0] value, input logic [7:0] code,
                              input logic [15:0] r, input logic [11:0] c, input logic last);
    plan_row_t row;
    row = '{PLAN_SAMPLE, d8fd_pkg::REG_RASTER_WIDTH, value, 1'b1, '{code, r, c, last}};
    directed_plan = {directed_plan, row};
  endtask

  // Check each popped word against the oldest expectation, and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        seen_cell = {direction, cell_row, cell_column, last_cell};
        if (pending_codes.size() == 0) begin
          report_mismatch("word with nothing expected", seen_cell, '0);
        end else begin
          want_cell = pending_codes.pop_front();
          if (seen_cell.direction !== want_cell.direction)
            report_mismatch("direction", seen_cell, want_cell);
          if (seen_cell.row !== want_cell.row) report_mismatch("cell_row", seen_cell, want_cell);
          if (seen_cell.col !== want_cell.col)
            report_mismatch("cell_column", seen_cell, want_cell);
          if (seen_cell.last !== want_cell.last)
            report_mismatch("last_cell", seen_cell, want_cell);
        end
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int slope [16];
    for (i = 0; i < CELLS_MAX; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (i = 0; i < 6; i++) window_col[i] = '0;

    // Smallest raster: the centre is the top elevation and every neighbour the
    // bottom one, so all eight tie and east wins. Border cells give code 0.
    plan_write(d8fd_pkg::REG_RASTER_WIDTH, 16'd3);
    plan_write(d8fd_pkg::REG_RASTER_HEIGHT, 16'd3);
    for (i = 0; i < 4; i++) plan_sample(32'h8000_0000);
    plan_checked(32'h7FFF_FFFF, 8'd0, 16'd0, 12'd0, 1'b0);
    plan_checked(32'h8000_0000, 8'd0, 16'd0, 12'd1, 1'b0);
    plan_sample(32'h8000_0000);
    plan_checked(32'h8000_0000, 8'd0, 16'd1, 12'd0, 1'b0);
    plan_checked(32'h8000_0000, 8'd1 << d8fd_pkg::DIR_E, 16'd1, 12'd1, 1'b1);
    // A 4 by 4 raster whose four interior cells drain NE, SE, SW and E,
    // with negative elevations below positive ones.
    plan_write(d8fd_pkg::REG_RASTER_WIDTH, 16'd4);
    plan_write(d8fd_pkg::REG_RASTER_HEIGHT, 16'd4);
    slope = '{50, 40, 30, -1, 60, 100, 90, 20, 70, 80, 95, -5, 10, 85, 99, 97};
    for (i = 0; i < 16; i++) plan_sample(slope[i]);

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[n]) begin
      if (directed_plan[n].kind == PLAN_WRITE)
        set_register(directed_plan[n].index, directed_plan[n].value[15:0]);
      else
        push_sample(directed_plan[n].value, directed_plan[n].typed, directed_plan[n].want_word);
    end

    // Register values below the minimum act as 3.
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd0);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd0);
    stream_samples(18);

    // Bits above the width register are dropped, leaving 5.
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'hE005);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd6);
    stream_samples(180);

    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd7);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd5);
    stream_samples(280);

    // Long stretch with no idling on either side, with one full drain midway.
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd16);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd6);
    send_gap_pct = 0;
    pop_stall_pct = 0;
    stream_samples(232);
    wait_drained();
    stream_samples(152);
    send_gap_pct = 7;
    pop_stall_pct = 7;

    // Heavy receiver stalls so that the block backs up and raises full.
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd9);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd9);
    pop_stall_pct = 60;
    stream_samples(243);
    pop_stall_pct = 7;

    // Tallest raster, cut short by a height write mid-raster; the row counter
    // is already past the new last row and wraps at the end of this row.
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd3);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'hFFFF);
    stream_samples(18);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd0);
    finish_raster();

    // Width shrinks mid-raster while the column counter is at the new last column.
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd10);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd7);
    stream_samples(175);
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd6);
    finish_raster();

    // Widest raster: a width above the maximum acts as the maximum. Part of the
    // first row goes in, then the width shrinks and the column counter, far past
    // the new last column, wraps on the next word.
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd8191);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd3);
    stream_samples(60);
    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd24);
    finish_raster();

    set_register(d8fd_pkg::REG_RASTER_WIDTH, 16'd4);
    set_register(d8fd_pkg::REG_RASTER_HEIGHT, 16'd3);
    stream_samples(120);

    // Let the last words come out, then a few more cycles for stray ones.
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
